>>> rtl/rdc_pkg.sv
package rdc_pkg;

  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd7;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

  typedef enum logic {
    FS_IDLE,
    FS_DIV
  } front_state_e;

  typedef enum logic {
    BS_IDLE,
    BS_RUN
  } back_state_e;

  // digit store write from the divider
  typedef struct packed {
    logic               en;
    logic               bank;
    logic [DIGIT_W-1:0] digit;
  } mem_wr_t;

  // back end hands a digit bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    code = CHAR_ZERO + CHAR_W'(d);
    if (d >= DIGIT_TEN) begin
      code = code + LETTER_OFFSET;
    end
    return code;
  endfunction

endpackage

>>> rtl/radix_digit_converter.sv
// radix_digit_converter
// Converts an unsigned integer into the ASCII digits of a radix from 2 to 16.
// Input stream s_axis: one item per value, the value in tdata.
// Output stream m_axis: one item per character, most significant digit first,
// tlast set on the final character of each value. A zero value gives "0".
// cfg_wr_en_i / cfg_wr_data_i set the radix; out-of-range codes saturate to
// 2 or 16. Write it only while no conversion is in progress.
// The divider makes four quotient bits per cycle through a shared
// restoring divider; the input side takes no new value until the
// current one is fully divided. Once its job is queued, the emitter gives
// one character per cycle from a two-bank digit store while m_axis is not
// stalled. A job queue lets the divider work on the next value while the
// previous one is still being emitted.
// Reset: radix returns to 10, all queues are emptied.
// Output stall: the emitter stops reading; once both digit banks are held
// the input side stops accepting items.
module radix_digit_converter import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 31
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [RADIX_W-1:0]                   cfg_wr_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: value, zero fill above
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: digit_char [6:0], zero at bit 7
  output logic [7:0]                           m_axis_tdata_o,
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  bank_rel_t        bank_rel;
  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] mem_wr_idx;
  logic             job_push, job_pop, job_empty, job_full;
  logic [CNT_W:0]   job_push_data, job_pop_data;

  rdc_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_value_i   (s_axis_tdata_i[VALUE_BITS-1:0]),
    .in_ready_o   (s_axis_tready_o),
    .bank_rel_i   (bank_rel),
    .job_push_o   (job_push),
    .job_data_o   (job_push_data),
    .mem_wr_o     (mem_wr),
    .mem_wr_idx_o (mem_wr_idx)
  );

  rdc_job_fifo #(
    .WIDTH(CNT_W + 1)
  ) u_job_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_push_data),
    .pop_i      (job_pop),
    .pop_data_o (job_pop_data),
    .empty_o    (job_empty),
    .full_o     (job_full)
  );

  rdc_back #(
    .MAX_DIGITS(MAX_DIGITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mem_wr_i       (mem_wr),
    .mem_wr_idx_i   (mem_wr_idx),
    .job_valid_i    (!job_empty),
    .job_data_i     (job_pop_data),
    .job_pop_o      (job_pop),
    .bank_rel_o     (bank_rel),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // bank ownership keeps the job queue from overflowing
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  // the divider never writes a bank that the emitter is just handing back
  a_bank_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr.en && bank_rel.valid) |-> (mem_wr.bank != bank_rel.bank))
    else $error("digit write into bank being released");

  // a job is queued only on the cycle the last digit is written
  a_push_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> mem_wr.en)
    else $error("job pushed without final digit write");
`endif

endmodule

>>> rtl/rdc_job_fifo.sv
module rdc_job_fifo import rdc_pkg::*; #(
  parameter int unsigned WIDTH = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o    = (cnt_q == 2'd0);
  assign full_o     = (cnt_q == 2'd2);
  assign pop_data_o = ent_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/rdc_front.sv
module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 31,
  parameter int unsigned IDX_W      = 5,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [RADIX_W-1:0]    cfg_wr_data_i,
  input  logic                  in_valid_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic                  in_ready_o,
  input  bank_rel_t             bank_rel_i,
  output logic                  job_push_o,
  output logic [CNT_W:0]        job_data_o,
  output mem_wr_t               mem_wr_o,
  output logic [IDX_W-1:0]      mem_wr_idx_o
);

  localparam int unsigned PAD_BITS = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned NSTEP    = PAD_BITS / STEP_BITS;
  localparam int unsigned STEP_W   = $clog2(NSTEP + 1);

  front_state_e        state_q, state_d;
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic [PAD_BITS-1:0] work_q, work_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                bank_q, bank_d;
  logic                next_bank_q, next_bank_d;
  logic [1:0]          busy_q, busy_d;

  logic                accept;
  logic                last_step;
  logic                div_done;
  logic [DIGIT_W:0]    div_rem;
  logic [PAD_BITS-1:0] div_work;

  // restoring long division, STEP_BITS quotient bits per cycle
  always_comb begin
    div_rem  = {1'b0, rem_q};
    div_work = work_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      div_rem  = {div_rem[DIGIT_W-1:0], div_work[PAD_BITS-1]};
      div_work = {div_work[PAD_BITS-2:0], 1'b0};
      if (div_rem >= radix_q) begin
        div_rem     = div_rem - radix_q;
        div_work[0] = 1'b1;
      end
    end
  end

  assign last_step = (step_q == STEP_W'(NSTEP - 1));
  assign div_done  = last_step &&
                     ((div_work == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          state_d = FS_DIV;
        end
      end
      FS_DIV: begin
        if (div_done) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    job_push_o   = 1'b0;
    mem_wr_o     = '0;
    mem_wr_idx_o = cnt_q[IDX_W-1:0];
    unique case (state_q)
      FS_IDLE: begin
        in_ready_o = !busy_q[next_bank_q];
      end
      FS_DIV: begin
        mem_wr_o.en    = last_step;
        mem_wr_o.bank  = bank_q;
        mem_wr_o.digit = div_rem[DIGIT_W-1:0];
        job_push_o     = div_done;
      end
      default: ;
    endcase
  end

  assign accept     = in_valid_i && in_ready_o;
  assign job_data_o = {bank_q, cnt_q + CNT_W'(1)};

  // datapath
  always_comb begin
    radix_d     = radix_q;
    work_d      = work_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    bank_d      = bank_q;
    next_bank_d = next_bank_q;
    busy_d      = busy_q;

    if (cfg_wr_en_i) begin
      if (cfg_wr_data_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (cfg_wr_data_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = cfg_wr_data_i;
      end
    end

    if (bank_rel_i.valid) begin
      busy_d[bank_rel_i.bank] = 1'b0;
    end

    if (accept) begin
      work_d                = PAD_BITS'(in_value_i);
      rem_d                 = '0;
      step_d                = '0;
      cnt_d                 = '0;
      bank_d                = next_bank_q;
      next_bank_d           = !next_bank_q;
      busy_d[next_bank_q]   = 1'b1;
    end else if (state_q == FS_DIV) begin
      work_d = div_work;
      rem_d  = div_rem[DIGIT_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (last_step) begin
        // start the next division on the fresh quotient
        rem_d  = '0;
        step_d = '0;
        cnt_d  = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      radix_q     <= RADIX_RESET;
      step_q      <= '0;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      next_bank_q <= 1'b0;
      busy_q      <= '0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      bank_q      <= bank_d;
      next_bank_q <= next_bank_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

endmodule

>>> rtl/rdc_back.sv
module rdc_back import rdc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 31,
  parameter int unsigned IDX_W      = 5,
  parameter int unsigned CNT_W      = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_wr_t          mem_wr_i,
  input  logic [IDX_W-1:0] mem_wr_idx_i,
  input  logic             job_valid_i,
  input  logic [CNT_W:0]   job_data_i,
  output logic             job_pop_o,
  output bank_rel_t        bank_rel_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  back_state_e        state_q, state_d;
  logic               bank_q, bank_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic               inflight_q, inflight_last_q;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [DIGIT_W-1:0] mem_q [2][MAX_DIGITS];

  // two-entry output queue of {last, char}
  logic [CHAR_W:0]    ob_q [2];
  logic               ob_wr_q, ob_rd_q;
  logic [1:0]         ob_cnt_q, ob_cnt_d;
  logic               out_pop;
  logic [1:0]         occ_sum;
  logic               issue;
  logic               issue_last;

  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = (ob_cnt_q != 2'd0);
  assign m_axis_tdata_o  = {1'b0, ob_q[ob_rd_q][CHAR_W-1:0]};
  assign m_axis_tlast_o  = ob_q[ob_rd_q][CHAR_W];

  // a read may start only if its char will find room in the output queue
  assign occ_sum    = ob_cnt_q + 2'(inflight_q) - 2'(out_pop);
  assign issue_last = (k_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (job_valid_i) begin
          state_d = BS_RUN;
        end
      end
      BS_RUN: begin
        if (issue && issue_last) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop_o  = 1'b0;
    issue      = 1'b0;
    bank_rel_o = '0;
    unique case (state_q)
      BS_IDLE: begin
        job_pop_o = job_valid_i;
      end
      BS_RUN: begin
        issue            = (occ_sum < 2'd2);
        bank_rel_o.valid = issue && issue_last;
        bank_rel_o.bank  = bank_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    bank_d = bank_q;
    k_d    = k_q;
    if (job_pop_o) begin
      bank_d = job_data_i[CNT_W];
      k_d    = IDX_W'(job_data_i[CNT_W-1:0] - CNT_W'(1));
    end else if (issue && !issue_last) begin
      k_d = k_q - IDX_W'(1);
    end
    ob_cnt_d = ob_cnt_q + 2'(inflight_q) - 2'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BS_IDLE;
      inflight_q <= 1'b0;
      ob_wr_q    <= 1'b0;
      ob_rd_q    <= 1'b0;
      ob_cnt_q   <= 2'd0;
    end else begin
      state_q    <= state_d;
      inflight_q <= issue;
      ob_wr_q    <= ob_wr_q ^ inflight_q;
      ob_rd_q    <= ob_rd_q ^ out_pop;
      ob_cnt_q   <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    k_q    <= k_d;
    if (issue) begin
      inflight_last_q <= issue_last;
    end
    if (inflight_q) begin
      ob_q[ob_wr_q] <= {inflight_last_q, digit_to_ascii(rd_data_q)};
    end
  end

  // digit store, two banks so the divider can run ahead of the emitter
  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.bank][mem_wr_idx_i] <= mem_wr_i.digit;
    end
    if (issue) begin
      rd_data_q <= mem_q[bank_q][k_q];
    end
  end

endmodule

>>> test/radix_checker.sv
module radix_checker
  import rdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [RADIX_W-1:0] cfg_wr_data_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [31:0]        s_tdata_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [7:0]         m_tdata_i,
  input  logic               m_tlast_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned DIGITS_N = 31;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_exp_t;

  char_exp_t          char_exp_q[$];
  char_exp_t          head;
  logic [RADIX_W-1:0] radix_q;

  // divide down by the saturated radix, queue the characters msd first
  function automatic void expand_value(input logic [VALUE_W-1:0] value,
                                       input logic [RADIX_W-1:0] code);
    logic [VALUE_W-1:0] rest;
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] digs [DIGITS_N];
    logic [CHAR_W-1:0]  ch;
    int                 n;
    if (code < RADIX_MIN) base = RADIX_MIN;
    else if (code > RADIX_MAX) base = RADIX_MAX;
    else base = code;
    rest = value;
    n = 0;
    if (rest == '0) begin
      digs[0] = '0;
      n = 1;
    end else begin
      while (rest != '0 && n < DIGITS_N) begin
        digs[n] = DIGIT_W'(rest % base);
        rest = rest / base;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      ch = CHAR_ZERO + CHAR_W'(digs[k]);
      if (digs[k] >= DIGIT_TEN) ch = ch + LETTER_OFFSET;
      char_exp_q.push_back('{code: ch, last: (k == 0)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      char_exp_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (char_exp_q.size() == 0) begin
          $error("digit_char: expected nothing, actual %0d (last_digit %0b)",
                 m_tdata_i[CHAR_W-1:0], m_tlast_i);
          fail_cnt_o++;
        end else begin
          head = char_exp_q.pop_front();
          if (m_tdata_i[CHAR_W-1:0] != head.code) begin
            $error("digit_char: expected %0d, actual %0d", head.code,
                   m_tdata_i[CHAR_W-1:0]);
            fail_cnt_o++;
          end
          if (m_tlast_i != head.last) begin
            $error("last_digit: expected %0b, actual %0b", head.last, m_tlast_i);
            fail_cnt_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) expand_value(s_tdata_i[VALUE_W-1:0], radix_q);
      if (cfg_wr_en_i) radix_q = cfg_wr_data_i;
    end
    pending_o = char_exp_q.size();
  end

endmodule

>>> test/tb_top.sv
module tb_top import rdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT       = 1000000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned RAND_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam logic [30:0] VALUE_MAX   = 31'h7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [RADIX_W-1:0] cfg_wr_data;
  logic               s_valid;
  logic               s_ready;
  logic [31:0]        s_data;
  logic               m_valid;
  logic               m_ready;
  logic [7:0]         m_data;
  logic               m_last;
  int                 fail_cnt;
  int                 pending;
  bit                 hold_req;
  int                 burst_left;

  always #5 clk = ~clk;

  radix_digit_converter uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  radix_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tlast_i    (m_last),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // bursty sender: valid stays up across a burst, random gaps in between
  task automatic offer_value(input logic [30:0] v);
    int gap;
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {1'b0, v};
    do @(posedge clk); while (!s_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        s_valid <= 1'b0;
        s_data  <= {1'b0, 31'($urandom)};
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // radix may only change once every queued character has drained
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mix of full-width, random-length and short values
  function automatic logic [30:0] pick_value();
    logic [30:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 31'($urandom);
      4, 5, 6:    v = 31'($urandom >> $urandom_range(1, 30));
      7, 8:       v = 31'($urandom_range(0, 300));
      default:    v = $urandom_range(0, 1) ? VALUE_MAX : '0;
    endcase
    return v;
  endfunction

  initial begin : sink
    int  span;
    int  mode;
    int  period;
    bit  hold_done;
    m_ready   = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      // one long stall so the block backs up into its input
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_ready <= 1'b0;
        end
      end
      span   = $urandom_range(10, 80);
      mode   = $urandom_range(0, 3);
      period = $urandom_range(2, 7);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= ($urandom_range(0, 3) != 0);
          default: m_ready <= ((i % period) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("radix_digit_converter: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [RADIX_W-1:0] r;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_valid     = 1'b0;
    s_data      = '0;
    hold_req    = 1'b0;
    burst_left  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset radix of ten
    offer_value(31'd0);
    offer_value(31'd1);
    offer_value(31'd9);
    offer_value(31'd10);
    offer_value(31'd99);
    offer_value(VALUE_MAX);
    offer_value(31'd1234567890);
    // binary: the largest value fills every digit slot
    set_radix(5'd2);
    offer_value(31'd0);
    offer_value(31'd1);
    offer_value(VALUE_MAX);
    offer_value(31'h4000_0000);
    // hex: letters
    set_radix(5'd16);
    offer_value(VALUE_MAX);
    offer_value(31'h0ABC_DEF0);
    offer_value(31'd15);
    offer_value(31'd16);
    // radix codes below range saturate to two
    set_radix(5'd0);
    offer_value(31'd5);
    offer_value(VALUE_MAX);
    set_radix(5'd1);
    offer_value(31'd6);
    // radix codes above range saturate to sixteen
    set_radix(5'd17);
    offer_value(31'd255);
    set_radix(5'd31);
    offer_value(VALUE_MAX);
    offer_value(31'd0);
    set_radix(5'd3);
    offer_value(31'd5555);

    hold_req = 1'b1;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) r = RADIX_MAX;
      else if (p == 1) r = RADIX_MIN;
      else r = RADIX_W'($urandom_range(0, 31));
      set_radix(r);
      repeat (PHASE_ITEMS) offer_value(pick_value());
    end

    @(negedge clk);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("radix_digit_converter: match");
    end else begin
      $display("radix_digit_converter: mismatch");
    end
    $finish;
  end

endmodule
